// ----- sv/dre_pkg.sv -----
// Shared types and constants for the DNS response address extractor.
`timescale 1ns / 1ps

package dre_pkg;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QLEN   = 4'd1,
    PH_QCHAR  = 4'd2,
    PH_QTAIL  = 4'd3,
    PH_RNAME  = 4'd4,
    PH_RLABEL = 4'd5,
    PH_RPTR   = 4'd6,
    PH_FIXED  = 4'd7,
    PH_RDATA  = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_NAME_END = 2'd1,
    KIND_ADDR     = 2'd2
  } kind_t;

  localparam logic [3:0]  HEADER_BYTES  = 4'd12;
  localparam logic [3:0]  QTAIL_BYTES   = 4'd4;
  localparam logic [3:0]  FIXED_BYTES   = 4'd10;
  localparam logic [3:0]  ADDR_BYTES    = 4'd4;
  localparam logic [7:0]  POINTER_MARK  = 8'hc0;
  localparam logic [15:0] TYPE_A        = 16'h0001;
  localparam logic [15:0] CLASS_IN      = 16'h0001;
  localparam logic [7:0]  DOT_CHAR      = 8'h2e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [31:0] item_value;
  } out_t;

  // parser result handed to the output register
  typedef struct packed {
    logic valid;
    out_t item;
  } result_t;

endpackage

// ----- sv/dre_parser.sv -----
// Byte-wise DNS response parser: phase registers and next-state logic.
`timescale 1ns / 1ps

module dre_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  dre_pkg::in_t     in_item,
  output dre_pkg::result_t result
);
  import dre_pkg::*;

  phase_t      parse_phase, parse_phase_next;
  logic [3:0]  field_byte_count, field_byte_count_next;
  logic [7:0]  label_bytes_left, label_bytes_left_next;
  logic        first_label_flag, first_label_flag_next;
  logic [31:0] assembly_shift, assembly_shift_next;
  logic [15:0] record_type_value, record_type_value_next;
  logic [15:0] record_class_value, record_class_value_next;
  logic [15:0] rdata_bytes_left, rdata_bytes_left_next;
  logic [7:0]  b;

  assign b = in_item.data_byte;

  always_comb begin
    parse_phase_next        = parse_phase;
    field_byte_count_next   = field_byte_count;
    label_bytes_left_next   = label_bytes_left;
    first_label_flag_next   = first_label_flag;
    assembly_shift_next     = assembly_shift;
    record_type_value_next  = record_type_value;
    record_class_value_next = record_class_value;
    rdata_bytes_left_next   = rdata_bytes_left;
    result.valid            = 1'b0;
    result.item.item_kind   = KIND_CHAR;
    result.item.item_value  = {24'd0, b};

    case (parse_phase)
      PH_QLEN: begin
        if (b == 8'd0) begin
          result.valid           = 1'b1;
          result.item.item_kind  = KIND_NAME_END;
          result.item.item_value = 32'd0;
          parse_phase_next       = PH_QTAIL;
          field_byte_count_next  = 4'd0;
        end else begin
          // every label after the first is preceded by a dot
          result.valid           = !first_label_flag;
          result.item.item_value = {24'd0, DOT_CHAR};
          first_label_flag_next  = 1'b0;
          label_bytes_left_next  = b;
          parse_phase_next       = PH_QCHAR;
        end
      end
      PH_QCHAR: begin
        result.valid          = 1'b1;
        label_bytes_left_next = label_bytes_left - 8'd1;
        if (label_bytes_left_next == 8'd0) parse_phase_next = PH_QLEN;
      end
      PH_QTAIL: begin
        field_byte_count_next = field_byte_count + 4'd1;
        if (field_byte_count_next >= QTAIL_BYTES) begin
          parse_phase_next      = PH_RNAME;
          field_byte_count_next = 4'd0;
        end
      end
      PH_RNAME: begin
        if ((b & POINTER_MARK) == POINTER_MARK) begin
          parse_phase_next = PH_RPTR;
        end else if (b == 8'd0) begin
          parse_phase_next      = PH_FIXED;
          field_byte_count_next = 4'd0;
        end else begin
          label_bytes_left_next = b;
          parse_phase_next      = PH_RLABEL;
        end
      end
      PH_RLABEL: begin
        label_bytes_left_next = label_bytes_left - 8'd1;
        if (label_bytes_left_next == 8'd0) parse_phase_next = PH_RNAME;
      end
      PH_RPTR: begin
        parse_phase_next      = PH_FIXED;
        field_byte_count_next = 4'd0;
      end
      PH_FIXED: begin
        // type, class, TTL (dropped), rdlength
        if (field_byte_count < 4'd2)
          record_type_value_next = {record_type_value[7:0], b};
        else if (field_byte_count < 4'd4)
          record_class_value_next = {record_class_value[7:0], b};
        else if (field_byte_count >= 4'd8)
          rdata_bytes_left_next = {rdata_bytes_left[7:0], b};
        field_byte_count_next = field_byte_count + 4'd1;
        if (field_byte_count_next >= FIXED_BYTES) begin
          field_byte_count_next = 4'd0;
          assembly_shift_next   = 32'd0;
          if (rdata_bytes_left_next == 16'd0) parse_phase_next = PH_RNAME;
          else parse_phase_next = PH_RDATA;
        end
      end
      PH_RDATA: begin
        if (field_byte_count < ADDR_BYTES) begin
          assembly_shift_next   = {assembly_shift[23:0], b};
          field_byte_count_next = field_byte_count + 4'd1;
        end
        rdata_bytes_left_next = rdata_bytes_left - 16'd1;
        if (rdata_bytes_left_next == 16'd0) begin
          result.valid           = (record_type_value == TYPE_A) &&
                                   (record_class_value == CLASS_IN) &&
                                   (field_byte_count_next >= ADDR_BYTES);
          result.item.item_kind  = KIND_ADDR;
          result.item.item_value = assembly_shift_next;
          parse_phase_next       = PH_RNAME;
          field_byte_count_next  = 4'd0;
        end
      end
      default: begin
        // header and unused codes
        field_byte_count_next = field_byte_count + 4'd1;
        parse_phase_next      = PH_HEADER;
        if (field_byte_count_next >= HEADER_BYTES) begin
          parse_phase_next      = PH_QLEN;
          field_byte_count_next = 4'd0;
          first_label_flag_next = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && in_item.end_of_packet)) begin
      parse_phase        <= PH_HEADER;
      field_byte_count   <= 4'd0;
      label_bytes_left   <= 8'd0;
      first_label_flag   <= 1'b1;
      assembly_shift     <= 32'd0;
      record_type_value  <= 16'd0;
      record_class_value <= 16'd0;
      rdata_bytes_left   <= 16'd0;
    end else if (advance) begin
      parse_phase        <= parse_phase_next;
      field_byte_count   <= field_byte_count_next;
      label_bytes_left   <= label_bytes_left_next;
      first_label_flag   <= first_label_flag_next;
      assembly_shift     <= assembly_shift_next;
      record_type_value  <= record_type_value_next;
      record_class_value <= record_class_value_next;
      rdata_bytes_left   <= rdata_bytes_left_next;
    end
  end

endmodule

// ----- sv/dre_out_reg.sv -----
// Output register holding one result until the receiver takes it.
`timescale 1ns / 1ps

module dre_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dre_pkg::out_t    load_item,
  output logic             full_stalled,
  output logic             out_valid,
  input  logic             out_stall,
  output dre_pkg::out_t    out_data
);
  import dre_pkg::*;

  logic held, held_next;
  out_t item;

  // a new result may replace one leaving in the same cycle
  assign full_stalled = held && out_stall;
  assign held_next    = load || full_stalled;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= load_item;
    end
  end

  assign out_valid = held;
  assign out_data  = item;

endmodule

// ----- sv/dns_response_address_extractor_core.sv -----
// Top level of the DNS response address extractor.
// Input channel: one message byte per transfer, end_of_packet set on the last
//   byte. Output channel: name characters, an end-of-name marker and IPv4
//   addresses of type A / class IN records.
// The parser consumes one byte per cycle while in_stall is low; its state
//   registers and the output register are written at the accepting edge, so
//   a result appears on the output in the cycle after the byte causing it.
// Throughput is one byte per cycle while in_stall is low; the single output
//   register is the only buffer, and a new result may load in the cycle the
//   previous one transfers.
// When the output holds a result and the receiver stalls, in_stall goes high
//   (combinationally from out_stall) until that result transfers.
// Synchronous reset returns the parser to the header phase and empties the
//   output register; the byte flagged end_of_packet does the same for the
//   parser at its own accepting edge, while its result loads the output.
`timescale 1ns / 1ps

module dns_response_address_extractor_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  dre_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dre_pkg::out_t out_data
);
  import dre_pkg::*;

  logic    accept;
  logic    full_stalled;
  result_t result;

  assign in_stall = full_stalled;
  assign accept   = in_valid && !full_stalled;

  dre_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .in_item (in_data),
    .result  (result)
  );

  dre_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && result.valid),
    .load_item    (result.item),
    .full_stalled (full_stalled),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
